// File: hw/rtl/gsll_pkg.sv
// gsll_pkg: shared types, codes and constants for the gmm state scorer
// no dependencies; used by every module of the block
`default_nettype none

package gsll_pkg;

  // request kinds carried in tuser of the input stream
  typedef enum logic [2:0] {
    REQ_FEATURE    = 3'd0,
    REQ_MEAN       = 3'd1,
    REQ_INV_VAR    = 3'd2,
    REQ_GCONST     = 3'd3,
    REQ_LOG_WEIGHT = 3'd4,
    REQ_SLOT       = 3'd5,
    REQ_SCORE      = 3'd6
  } req_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_VECTOR_LEN = 2'd0,
    CFG_START_DIM  = 2'd1,
    CFG_MIXTURES   = 2'd2
  } cfg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CACHE,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_GC,
    ST_DIM,
    ST_DRAIN,
    ST_FIN_NEG,
    ST_FIN_SAT,
    ST_OUT
  } state_e;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic init;  // load accumulator with gconst
    logic vld;   // feature, mean and inverse variance beat present
  } mac_ctl_t;

  localparam int ScoreW = 32;
  localparam int AccW   = 64;
  localparam int EpochW = 8;

  localparam logic [6:0] VectorLenRst = 7'd39;
  localparam logic [5:0] StartDimRst  = 6'd0;
  localparam logic [4:0] MixturesRst  = 5'd8;

  localparam logic signed [ScoreW-1:0] ScoreMin = 32'sh8000_0000;
  localparam logic signed [ScoreW-1:0] ScoreMax = 32'sh7fff_ffff;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gsll_ram.sv
// gsll_ram: generic single-write, single-read memory with registered read
// depends on gsll_pkg for the address width helper
`default_nettype none

module gsll_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int Aw = gsll_pkg::addr_w(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/gsll_mac.sv
// gsll_mac: shared pipelined unit, (x - mu)^2 * iv accumulated onto gconst
// depends on gsll_pkg
`default_nettype none

module gsll_mac (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire gsll_pkg::mac_ctl_t     ctl_i,
  input  wire logic signed [31:0]     gconst_i,
  input  wire logic signed [15:0]     feat_i,
  input  wire logic signed [15:0]     mean_i,
  input  wire logic signed [15:0]     iv_i,
  output logic signed [gsll_pkg::AccW-1:0] acc_o,
  output logic                        busy_o
);

  logic signed [16:0] diff;
  logic signed [33:0] sq_full;
  logic        [31:0] sq_q;
  logic signed [15:0] iv_q;
  logic signed [48:0] prod_d, prod_q;
  logic               sq_vld_q, prod_vld_q;
  logic signed [gsll_pkg::AccW-1:0] acc_q;

  assign diff    = 17'(feat_i) - 17'(mean_i);
  assign sq_full = diff * diff;
  assign prod_d  = $signed({1'b0, sq_q}) * iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      sq_vld_q   <= ctl_i.vld;
      prod_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_full[31:0];
    iv_q   <= iv_i;
    prod_q <= prod_d;
    if (ctl_i.init) begin
      acc_q <= {{16{gconst_i[31]}}, gconst_i, 16'h0000};
    end else if (prod_vld_q) begin
      acc_q <= acc_q + gsll_pkg::AccW'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = sq_vld_q | prod_vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/gmm_state_log_likelihood_scorer_top.sv
// gmm_state_log_likelihood_scorer_top: state scorer, sequencer and stores
// depends on gsll_pkg, gsll_ram and gsll_mac
//
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: request fields, tuser: kind
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: score, tuser: from_cache
//  cfg      | in        | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
// the single multiply-accumulate unit and one read port per store set the
//   rate of the dimension walk: one dimension per cycle
// after reset a clearing pass empties the slot map and cache; every 255th
//   in-range feature write triggers a pass over the cache tags; no beat is
//   taken meanwhile
// a finished result waits in the output register while new loads go on; a
//   second result holds the sequencer until the first is taken, and no beat
//   is taken meanwhile
`default_nettype none

module gmm_state_log_likelihood_scorer_top #(
  parameter int NUM_STATES   = 1024,
  parameter int NUM_MIXTURES = 1024,
  parameter int MAX_DIM      = 64,
  parameter int MAX_SLOTS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: state_index[9:0], mixture_index[19:10], slot[23:20],
  // slot_used[24], dim[30:25], value[62:31], zero pad[63]
  input  wire logic [63:0] s_axis_tdata,
  // tuser: req_type[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: score[31:0]
  output logic [31:0]      m_axis_tdata,
  // tuser: from_cache[0]
  output logic [0:0]       m_axis_tuser,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i
);

  localparam int FDepth = MAX_DIM;
  localparam int MDepth = NUM_MIXTURES * MAX_DIM;
  localparam int SDepth = NUM_STATES * MAX_SLOTS;
  localparam int Faw    = gsll_pkg::addr_w(FDepth);
  localparam int Maw    = gsll_pkg::addr_w(MDepth);
  localparam int Mxw    = gsll_pkg::addr_w(NUM_MIXTURES);
  localparam int Saw    = gsll_pkg::addr_w(SDepth);
  localparam int Stw    = gsll_pkg::addr_w(NUM_STATES);
  localparam int SweepN = (SDepth > NUM_STATES) ? SDepth : NUM_STATES;
  localparam int Sww    = gsll_pkg::addr_w(SweepN);
  localparam int DcwRaw = $clog2(MAX_DIM + 1);
  localparam int Dcw    = (DcwRaw > 7) ? DcwRaw : 7;
  localparam int ScwRaw = $clog2(MAX_SLOTS + 1);
  localparam int Scw    = (ScwRaw > 5) ? ScwRaw : 5;
  localparam int CacheW = gsll_pkg::EpochW + gsll_pkg::ScoreW;

  // request fields
  logic [9:0]  in_st, in_mix;
  logic [3:0]  in_slot;
  logic        in_used;
  logic [5:0]  in_dim;
  logic [31:0] in_val;
  logic        in_acc;

  assign in_st   = s_axis_tdata[9:0];
  assign in_mix  = s_axis_tdata[19:10];
  assign in_slot = s_axis_tdata[23:20];
  assign in_used = s_axis_tdata[24];
  assign in_dim  = s_axis_tdata[30:25];
  assign in_val  = s_axis_tdata[62:31];
  assign in_acc  = s_axis_tvalid & s_axis_tready;

  // configuration
  logic [6:0] vlen_q;
  logic [5:0] sdim_q;
  logic [4:0] mps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= gsll_pkg::VectorLenRst;
      sdim_q <= gsll_pkg::StartDimRst;
      mps_q  <= gsll_pkg::MixturesRst;
    end else if (cfg_we_i) begin
      case (gsll_pkg::cfg_e'(cfg_idx_i))
        gsll_pkg::CFG_VECTOR_LEN: vlen_q <= cfg_wdata_i;
        gsll_pkg::CFG_START_DIM:  sdim_q <= cfg_wdata_i[5:0];
        gsll_pkg::CFG_MIXTURES:   mps_q  <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  logic [Dcw-1:0] dim_end;
  logic [Scw-1:0] nslots;
  assign dim_end = (Dcw'(vlen_q) > Dcw'(MAX_DIM)) ? Dcw'(MAX_DIM) : Dcw'(vlen_q);
  assign nslots  = (Scw'(mps_q) > Scw'(MAX_SLOTS)) ? Scw'(MAX_SLOTS) : Scw'(mps_q);

  // sequencer and datapath registers
  gsll_pkg::state_e state_q, state_d;
  logic [Sww-1:0]   sweep_q, sweep_d;
  logic             sweep_slots_q, sweep_slots_d;
  logic [gsll_pkg::EpochW-1:0] epoch_q, epoch_d;
  logic [Stw-1:0]   st_q, st_d;
  logic [Scw-1:0]   s_q, s_d;
  logic [Dcw-1:0]   d_q, d_d;
  logic [Mxw-1:0]   mix_q, mix_d;
  logic             issued_q, issued_d;
  logic signed [31:0] logw_q, logw_d;
  logic signed [gsll_pkg::AccW-1:0] neg_q, neg_d;
  logic signed [31:0] best_q, best_d;
  logic signed [31:0] res_q, res_d;
  logic             res_fc_q, res_fc_d;
  logic             out_vld_q, out_vld_d;
  logic [31:0]      out_score_q, out_score_d;
  logic             out_fc_q, out_fc_d;

  // store ports
  logic             f_we;  logic [Faw-1:0] f_wa, f_ra;  logic [15:0] f_rd;
  logic             mu_we; logic [Maw-1:0] m_wa, m_ra;  logic [15:0] mu_rd;
  logic             iv_we;                              logic [15:0] iv_rd;
  logic             g_we;  logic [Mxw-1:0] g_wa, g_ra;  logic [31:0] g_rd;
  logic             lw_we;                              logic [31:0] lw_rd;
  logic             sm_we; logic [Saw-1:0] sm_wa, sm_ra;
  logic [Mxw:0]     sm_wd, sm_rd;
  logic             c_we;  logic [Stw-1:0] c_wa, c_ra;
  logic [CacheW-1:0] c_wd, c_rd;

  gsll_pkg::mac_ctl_t mac_ctl;
  logic signed [gsll_pkg::AccW-1:0] mac_acc;
  logic mac_busy;

  logic dim_ok, mix_ok, st_ok, slot_ok, sweep_last;
  logic signed [46:0] sh;
  logic signed [47:0] sum;
  logic signed [31:0] sx;

  assign dim_ok     = (32'(in_dim) < MAX_DIM);
  assign mix_ok     = (32'(in_mix) < NUM_MIXTURES);
  assign st_ok      = (32'(in_st) < NUM_STATES);
  assign slot_ok    = (32'(in_slot) < MAX_SLOTS);
  // the pass after reset also covers the slot map; later passes only the cache
  assign sweep_last = sweep_slots_q ? (32'(sweep_q) == SweepN - 1)
                                    : (32'(sweep_q) == NUM_STATES - 1);

  // floor of -acc / 2^17, plus log weight, saturated
  assign sh  = neg_q[gsll_pkg::AccW-1:17];
  assign sum = 48'(sh) + 48'(logw_q);
  always_comb begin
    if (sum > 48'(gsll_pkg::ScoreMax)) begin
      sx = gsll_pkg::ScoreMax;
    end else if (sum < 48'(gsll_pkg::ScoreMin)) begin
      sx = gsll_pkg::ScoreMin;
    end else begin
      sx = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gsll_pkg::ST_SWEEP: begin
        if (sweep_last) state_d = gsll_pkg::ST_IDLE;
      end
      gsll_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (gsll_pkg::req_e'(s_axis_tuser))
            gsll_pkg::REQ_FEATURE: begin
              if (dim_ok && (epoch_q == '1)) state_d = gsll_pkg::ST_SWEEP;
            end
            gsll_pkg::REQ_SCORE: begin
              state_d = st_ok ? gsll_pkg::ST_CACHE : gsll_pkg::ST_OUT;
            end
            default: ;
          endcase
        end
      end
      gsll_pkg::ST_CACHE: begin
        if (c_rd[CacheW-1 -: gsll_pkg::EpochW] == epoch_q) state_d = gsll_pkg::ST_OUT;
        else state_d = gsll_pkg::ST_SLOT_RD;
      end
      gsll_pkg::ST_SLOT_RD: begin
        state_d = (s_q < nslots) ? gsll_pkg::ST_SLOT_CHK : gsll_pkg::ST_OUT;
      end
      gsll_pkg::ST_SLOT_CHK: begin
        state_d = sm_rd[Mxw] ? gsll_pkg::ST_GC : gsll_pkg::ST_SLOT_RD;
      end
      gsll_pkg::ST_GC:      state_d = gsll_pkg::ST_DIM;
      gsll_pkg::ST_DIM: begin
        if (d_q >= dim_end) state_d = gsll_pkg::ST_DRAIN;
      end
      gsll_pkg::ST_DRAIN: begin
        if (!issued_q && !mac_busy) state_d = gsll_pkg::ST_FIN_NEG;
      end
      gsll_pkg::ST_FIN_NEG: state_d = gsll_pkg::ST_FIN_SAT;
      gsll_pkg::ST_FIN_SAT: state_d = gsll_pkg::ST_SLOT_RD;
      gsll_pkg::ST_OUT: begin
        if (!out_vld_q || m_axis_tready) state_d = gsll_pkg::ST_IDLE;
      end
      default: state_d = gsll_pkg::ST_IDLE;
    endcase
  end

  // outputs, store controls and datapath
  always_comb begin
    s_axis_tready = (state_q == gsll_pkg::ST_IDLE);
    sweep_d       = sweep_q;
    sweep_slots_d = sweep_slots_q;
    epoch_d       = epoch_q;
    st_d          = st_q;
    s_d           = s_q;
    d_d           = d_q;
    mix_d         = mix_q;
    issued_d      = 1'b0;
    logw_d        = logw_q;
    neg_d         = neg_q;
    best_d        = best_q;
    res_d         = res_q;
    res_fc_d      = res_fc_q;
    out_vld_d     = out_vld_q & ~m_axis_tready;
    out_score_d   = out_score_q;
    out_fc_d      = out_fc_q;
    mac_ctl       = '0;

    f_we  = 1'b0; f_wa = Faw'(in_dim); f_ra = d_q[Faw-1:0];
    mu_we = 1'b0; iv_we = 1'b0;
    m_wa  = Maw'(Maw'(in_mix) * Maw'(MAX_DIM)) + Maw'(in_dim);
    m_ra  = Maw'(Maw'(mix_q) * Maw'(MAX_DIM)) + Maw'(d_q);
    g_we  = 1'b0; lw_we = 1'b0; g_wa = Mxw'(in_mix); g_ra = sm_rd[Mxw-1:0];
    sm_we = 1'b0;
    sm_wa = Saw'(Saw'(in_st) * Saw'(MAX_SLOTS)) + Saw'(in_slot);
    sm_wd = {in_used, Mxw'(in_mix)};
    sm_ra = Saw'(Saw'(st_q) * Saw'(MAX_SLOTS)) + Saw'(s_q);
    c_we  = 1'b0; c_wa = st_q; c_wd = {epoch_q, best_q}; c_ra = Stw'(in_st);

    case (state_q)
      gsll_pkg::ST_SWEEP: begin
        // tag zero never matches a live epoch
        c_we  = (32'(sweep_q) < NUM_STATES);
        c_wa  = Stw'(sweep_q);
        c_wd  = '0;
        sm_we = sweep_slots_q && (32'(sweep_q) < SDepth);
        sm_wa = Saw'(sweep_q);
        sm_wd = '0;
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          sweep_d       = '0;
          sweep_slots_d = 1'b0;
        end
      end
      gsll_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (gsll_pkg::req_e'(s_axis_tuser))
            gsll_pkg::REQ_FEATURE: begin
              f_we = dim_ok;
              if (dim_ok) begin
                epoch_d = (epoch_q == '1) ? gsll_pkg::EpochW'(1) : epoch_q + 1'b1;
              end
            end
            gsll_pkg::REQ_MEAN:       mu_we = dim_ok && mix_ok;
            gsll_pkg::REQ_INV_VAR:    iv_we = dim_ok && mix_ok;
            gsll_pkg::REQ_GCONST:     g_we  = mix_ok;
            gsll_pkg::REQ_LOG_WEIGHT: lw_we = mix_ok;
            gsll_pkg::REQ_SLOT:       sm_we = st_ok && slot_ok && mix_ok;
            gsll_pkg::REQ_SCORE: begin
              st_d     = Stw'(in_st);
              res_d    = gsll_pkg::ScoreMin;
              res_fc_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      gsll_pkg::ST_CACHE: begin
        res_d    = c_rd[31:0];
        res_fc_d = 1'b1;
        s_d      = '0;
        best_d   = gsll_pkg::ScoreMin;
      end
      gsll_pkg::ST_SLOT_RD: begin
        if (s_q >= nslots) begin
          c_we     = 1'b1;
          res_d    = best_q;
          res_fc_d = 1'b0;
        end
      end
      gsll_pkg::ST_SLOT_CHK: begin
        mix_d = sm_rd[Mxw-1:0];
        if (!sm_rd[Mxw]) s_d = s_q + 1'b1;
      end
      gsll_pkg::ST_GC: begin
        mac_ctl.init = 1'b1;
        logw_d       = lw_rd;
        d_d          = Dcw'(sdim_q);
      end
      gsll_pkg::ST_DIM: begin
        if (d_q < dim_end) begin
          issued_d = 1'b1;
          d_d      = d_q + 1'b1;
        end
      end
      gsll_pkg::ST_FIN_NEG: neg_d = -mac_acc;
      gsll_pkg::ST_FIN_SAT: begin
        if (sx > best_q) best_d = sx;
        s_d = s_q + 1'b1;
      end
      gsll_pkg::ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d   = 1'b1;
          out_score_d = res_q;
          out_fc_d    = res_fc_q;
        end
      end
      default: ;
    endcase
    mac_ctl.vld = issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= gsll_pkg::ST_SWEEP;
      sweep_q       <= '0;
      sweep_slots_q <= 1'b1;
      epoch_q       <= gsll_pkg::EpochW'(1);
      issued_q      <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      sweep_q       <= sweep_d;
      sweep_slots_q <= sweep_slots_d;
      epoch_q       <= epoch_d;
      issued_q      <= issued_d;
      out_vld_q     <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q        <= st_d;
    s_q         <= s_d;
    d_q         <= d_d;
    mix_q       <= mix_d;
    logw_q      <= logw_d;
    neg_q       <= neg_d;
    best_q      <= best_d;
    res_q       <= res_d;
    res_fc_q    <= res_fc_d;
    out_score_q <= out_score_d;
    out_fc_q    <= out_fc_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_score_q;
  assign m_axis_tuser  = out_fc_q;

  // stores
  gsll_ram #(.Width(16), .Depth(FDepth)) u_feat (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(in_val[15:0]),
    .raddr_i(f_ra), .rdata_o(f_rd)
  );
  gsll_ram #(.Width(16), .Depth(MDepth)) u_mean (
    .clk_i, .we_i(mu_we), .waddr_i(m_wa), .wdata_i(in_val[15:0]),
    .raddr_i(m_ra), .rdata_o(mu_rd)
  );
  gsll_ram #(.Width(16), .Depth(MDepth)) u_inv_var (
    .clk_i, .we_i(iv_we), .waddr_i(m_wa), .wdata_i(in_val[15:0]),
    .raddr_i(m_ra), .rdata_o(iv_rd)
  );
  gsll_ram #(.Width(32), .Depth(NUM_MIXTURES)) u_gconst (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(in_val),
    .raddr_i(g_ra), .rdata_o(g_rd)
  );
  gsll_ram #(.Width(32), .Depth(NUM_MIXTURES)) u_log_weight (
    .clk_i, .we_i(lw_we), .waddr_i(g_wa), .wdata_i(in_val),
    .raddr_i(g_ra), .rdata_o(lw_rd)
  );
  gsll_ram #(.Width(Mxw + 1), .Depth(SDepth)) u_slot_map (
    .clk_i, .we_i(sm_we), .waddr_i(sm_wa), .wdata_i(sm_wd),
    .raddr_i(sm_ra), .rdata_o(sm_rd)
  );
  gsll_ram #(.Width(CacheW), .Depth(NUM_STATES)) u_cache (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .raddr_i(c_ra), .rdata_o(c_rd)
  );

  gsll_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(mac_ctl), .gconst_i(g_rd),
    .feat_i(f_rd), .mean_i(mu_rd), .iv_i(iv_rd),
    .acc_o(mac_acc), .busy_o(mac_busy)
  );

  // checks
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0) else $error("epoch tag zero is reserved for cleared entries");

  a_mac_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_busy || issued_q) |-> (state_q == gsll_pkg::ST_DIM || state_q == gsll_pkg::ST_DRAIN))
    else $error("multiply-accumulate active outside dimension walk");

  a_fin_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsll_pkg::ST_FIN_NEG) |-> (!mac_busy && !issued_q))
    else $error("finish started with beats still in flight");

  a_no_beat_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsll_pkg::ST_SWEEP) |-> !s_axis_tready)
    else $error("beat taken during clearing pass");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsll_pkg::ST_OUT && state_d == gsll_pkg::ST_IDLE) |=> m_axis_tvalid)
    else $error("result lost on leaving output state");

endmodule

`default_nettype wire
